// ----- hw/rtl/wpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// wpsc_pkg
// Widths, register indexes and fixed-point constants shared by the windowed
// PID speed controller and its channel interfaces.
// ----------------------------------------------------------------------------
package wpsc_pkg;

  localparam int SPEED_W   = 16;  // Q8.8 speed samples
  localparam int ERR_W     = SPEED_W + 1;
  localparam int GAIN_W    = 24;  // Q8.16 gains
  localparam int DRIVE_W   = 13;  // Q12 drive, 0..4096
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 24;  // raw drive fraction bits (Q.24)
  localparam int OUT_SHIFT = 12;  // Q.24 -> Q12

  typedef logic [CFG_IDX_W-1:0]        cfg_index_t;
  typedef logic signed [SPEED_W-1:0]   speed_t;
  typedef logic signed [ERR_W-1:0]     err_t;
  typedef logic signed [GAIN_W-1:0]    gain_t;
  typedef logic [DRIVE_W-1:0]          drive_t;

  localparam cfg_index_t REG_KP     = 2'd0;
  localparam cfg_index_t REG_KD_EFF = 2'd1;
  localparam cfg_index_t REG_KI_EFF = 2'd2;

  localparam logic [FRAC_W:0] HALF_OUT_LSB = 25'h0000800;
  localparam drive_t          DRIVE_FULL   = 13'd4096;
  localparam drive_t          DRIVE_ZERO   = 13'd0;

endpackage

// ----- hw/rtl/wpsc_in_if.sv -----
// ----------------------------------------------------------------------------
// wpsc_in_if
// Speed sample channel: measured and wanted speed with valid/ready.
// ----------------------------------------------------------------------------
interface wpsc_in_if
  import wpsc_pkg::*;
();
  logic   valid;
  logic   ready;
  speed_t measured_speed;
  speed_t wanted_speed;

  modport source (output valid, output measured_speed, output wanted_speed, input ready);
  modport sink   (input valid, input measured_speed, input wanted_speed, output ready);
endinterface

// ----- hw/rtl/wpsc_out_if.sv -----
// ----------------------------------------------------------------------------
// wpsc_out_if
// Drive command channel: throttle level and clamp flag with valid/ready.
// ----------------------------------------------------------------------------
interface wpsc_out_if
  import wpsc_pkg::*;
();
  logic   valid;
  logic   ready;
  drive_t drive_level;
  logic   was_clamped;

  modport source (output valid, output drive_level, output was_clamped, input ready);
  modport sink   (input valid, input drive_level, input was_clamped, output ready);
endinterface

// ----- hw/rtl/wpsc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// wpsc_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface wpsc_cfg_if
  import wpsc_pkg::*;
();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  gain_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/windowed_pid_speed_controller_top.sv -----
// ----------------------------------------------------------------------------
// windowed_pid_speed_controller_top
// Speed PID with a sliding-window integral over the last WINDOW_LEN errors.
// ----------------------------------------------------------------------------
// Usage:
//   sample  - one transaction per control tick: measured_speed, wanted_speed
//             (signed Q8.8). The error is pushed into a shift line of the
//             last WINDOW_LEN errors and a running sum is updated on accept.
//   drive   - one transaction per sample: drive_level (Q12, 0..4096) and
//             was_clamped, set when the raw drive fell outside 0..1.
//   cfg     - register writes: index 0 kp, 1 kd_eff, 2 ki_eff (Q8.16).
//             Always ready; other indexes are ignored. Write only while idle.
// Pipeline: error/window stage, product stage, sum/saturate stage into the
//   output register; drive valid rises once a sample has passed all of them.
// Throughput: one sample per cycle unless drive back-pressure stalls; each stage
//   is limited by one 24-bit by up-to-22-bit multiply or one wide add and compare.
// Reset: gains, error count and window sum clear; the pipeline empties.
//   Derivative and integral terms stay off until two errors are stored.
// Stall: each stage holds while the next one is full and not draining, so
//   samples keep entering until all three stages hold results.
// ----------------------------------------------------------------------------
module windowed_pid_speed_controller_top
  import wpsc_pkg::*;
#(
  parameter int WINDOW_LEN = 30
) (
  input  logic   clk,
  input  logic   rst,
  wpsc_in_if.sink    sample,
  wpsc_out_if.source drive,
  wpsc_cfg_if.sink   cfg
);

  localparam int SUM_W = ERR_W + $clog2(WINDOW_LEN);
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int DIFF_W = ERR_W + 1;
  localparam int P_W = GAIN_W + ERR_W;
  localparam int D_W = GAIN_W + DIFF_W;
  localparam int I_W = GAIN_W + SUM_W;
  localparam int RAW_W = I_W + 2;
  localparam logic signed [RAW_W-1:0] ONE_RAW = RAW_W'(25'h1000000);

  // Gains
  gain_t kp;
  gain_t kd_eff;
  gain_t ki_eff;

  // Window state
  err_t                     err_line [WINDOW_LEN];
  logic signed [SUM_W-1:0]  window_sum;
  logic [FILL_W-1:0]        fill_count;

  // Stage 1: error, difference, sum
  logic                     v1;
  err_t                     s1_err;
  logic signed [DIFF_W-1:0] s1_diff;
  logic signed [SUM_W-1:0]  s1_sum;

  // Stage 2: products
  logic                     v2;
  logic signed [P_W-1:0]    p_prod;
  logic signed [D_W-1:0]    d_prod;
  logic signed [I_W-1:0]    i_prod;

  // Stage 3: output register
  logic                     out_valid;
  drive_t                   out_level;
  logic                     out_clamped;

  // Combinational
  logic                     out_free;
  logic                     s2_free;
  logic                     s1_free;
  logic                     accept;
  err_t                     err;
  logic                     full;
  logic                     terms_on;
  logic signed [SUM_W-1:0]  window_sum_next;
  logic signed [RAW_W-1:0]  raw;
  logic [FRAC_W:0]          rounded;
  drive_t                   level_next;
  logic                     clamped_next;

  assign out_free = !out_valid || drive.ready;
  assign s2_free  = !v2 || out_free;
  assign s1_free  = !v1 || s2_free;
  assign accept   = sample.valid && s1_free;

  assign sample.ready      = s1_free;
  assign drive.valid       = out_valid;
  assign drive.drive_level = out_level;
  assign drive.was_clamped = out_clamped;
  assign cfg.ready         = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp     <= '0;
      kd_eff <= '0;
      ki_eff <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KP:     kp     <= cfg.data;
        REG_KD_EFF: kd_eff <= cfg.data;
        REG_KI_EFF: ki_eff <= cfg.data;
        default: ;
      endcase
    end
  end

  assign err  = ERR_W'(sample.wanted_speed) - ERR_W'(sample.measured_speed);
  assign full = (fill_count == FILL_W'(WINDOW_LEN));
  // Two or more errors stored after the push exactly when at least one was stored before
  assign terms_on = (fill_count != '0);

  // Drop the oldest error once the window is full
  assign window_sum_next = window_sum + SUM_W'(err)
                         - (full ? SUM_W'(err_line[WINDOW_LEN-1]) : SUM_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      fill_count <= '0;
    end else if (accept) begin
      window_sum <= window_sum_next;
      if (!full) begin
        fill_count <= fill_count + FILL_W'(1);
      end
    end
  end

  // Shift line of errors, newest at tap 0
  always_ff @(posedge clk) begin
    if (accept) begin
      err_line[0] <= err;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        err_line[i] <= err_line[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_free) begin
      v1 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err  <= err;
      s1_diff <= terms_on ? DIFF_W'(err) - DIFF_W'(err_line[0]) : '0;
      s1_sum  <= terms_on ? window_sum_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && v1) begin
      p_prod <= P_W'(kp) * P_W'(s1_err);
      d_prod <= D_W'(kd_eff) * D_W'(s1_diff);
      i_prod <= I_W'(ki_eff) * I_W'(s1_sum);
    end
  end

  assign raw = RAW_W'(p_prod) + RAW_W'(d_prod) + RAW_W'(i_prod);
  assign rounded = raw[FRAC_W:0] + HALF_OUT_LSB;

  always_comb begin
    if (raw < 0) begin
      level_next   = DRIVE_ZERO;
      clamped_next = 1'b1;
    end else if (raw > ONE_RAW) begin
      level_next   = DRIVE_FULL;
      clamped_next = 1'b1;
    end else begin
      level_next   = rounded[FRAC_W:OUT_SHIFT];
      clamped_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v2) begin
      out_level   <= level_next;
      out_clamped <= clamped_next;
    end
  end

  // Error count never runs past the window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW_LEN))
    else $error("fill_count beyond window length");

  // Count advances by one per accepted sample until full
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !full) |=> fill_count == $past(fill_count) + FILL_W'(1))
    else $error("fill_count did not advance on accept");

  // A clamped result sits at one of the rails
  a_clamp_rail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_clamped) |-> (out_level == DRIVE_ZERO || out_level == DRIVE_FULL))
    else $error("clamped drive not at a rail");

  // Drive never exceeds full throttle
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_level <= DRIVE_FULL)
    else $error("drive level above full scale");

  // A held stage moves only when the next one takes it
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !out_free) |=> v2 && $stable(i_prod))
    else $error("product stage lost while stalled");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed PID speed controller. Speed samples
// go in through valid/ready with random gaps. A software copy of the error
// window, running sum and gains predicts each drive level and clamp flag.
// Drive results come out under random back-pressure, including one long
// hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import wpsc_pkg::*;

  localparam int WINDOW_LEN      = 30;
  localparam int PIPE_LATENCY    = 3;
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_LIMIT     = 2000;
  localparam int MAX_REPORTS     = 40;

  localparam cfg_index_t REG_UNUSED = 2'd3;

  typedef struct packed {
    drive_t level;
    logic   clamped;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst;

  wpsc_in_if  sample_ch ();
  wpsc_out_if drive_ch ();
  wpsc_cfg_if cfg_ch ();

  windowed_pid_speed_controller_top #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .sample(sample_ch),
    .drive (drive_ch),
    .cfg   (cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the controller state
  err_t   err_window [WINDOW_LEN];
  longint err_sum;
  int     err_count;
  int     next_slot;
  longint gain_kp;
  longint gain_kd;
  longint gain_ki;

  drive_result_t expected_drive[$];
  drive_result_t want;

  int  mismatches    = 0;
  int  samples_sent  = 0;
  int  results_seen  = 0;
  int  clamped_seen  = 0;
  int  gain_writes   = 0;
  int  cycle_count   = 0;
  bit  allow_idle    = 1'b1;
  bit  hold_off_req  = 1'b0;

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Push one error into the window and compute the saturated drive.
  function automatic drive_result_t predict_drive(speed_t measured, speed_t wanted);
    longint        err;
    longint        prev;
    longint        raw;
    drive_result_t res;
    err  = longint'(wanted) - longint'(measured);
    prev = longint'(err_window[(next_slot + WINDOW_LEN - 1) % WINDOW_LEN]);
    if (err_count >= WINDOW_LEN) begin
      err_sum -= longint'(err_window[next_slot]);
    end else begin
      err_count++;
    end
    err_window[next_slot] = err_t'(err);
    err_sum += err;
    next_slot = (next_slot + 1) % WINDOW_LEN;

    raw = gain_kp * err;
    if (err_count >= 2) begin
      raw += gain_kd * (err - prev);
      raw += gain_ki * err_sum;
    end

    if (raw < 0) begin
      res.level   = DRIVE_ZERO;
      res.clamped = 1'b1;
    end else if (raw > (longint'(1) << FRAC_W)) begin
      res.level   = DRIVE_FULL;
      res.clamped = 1'b1;
    end else begin
      res.level   = drive_t'((raw + longint'(HALF_OUT_LSB)) >> OUT_SHIFT);
      res.clamped = 1'b0;
    end
    return res;
  endfunction

  task automatic send_sample(speed_t measured, speed_t wanted);
    int            gap;
    drive_result_t pred;
    gap = (allow_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      sample_ch.valid = 1'b0;
    end
    @(negedge clk);
    sample_ch.valid          = 1'b1;
    sample_ch.measured_speed = measured;
    sample_ch.wanted_speed   = wanted;
    do @(posedge clk); while (!sample_ch.ready);
    pred = predict_drive(measured, wanted);
    expected_drive = {expected_drive, pred};
    samples_sent++;
  endtask

  task automatic write_gain(cfg_index_t idx, gain_t val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_KP:     gain_kp = longint'(val);
      REG_KD_EFF: gain_kd = longint'(val);
      REG_KI_EFF: gain_ki = longint'(val);
      default: ;  // unmapped index: drop
    endcase
    gain_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Drop valid, let every pending result drain, then cover the pipeline depth.
  task automatic wait_idle();
    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  function automatic gain_t rand_gain(int cls);
    case (cls)
      0: begin
        case ($urandom_range(0, 2))
          0:       return gain_t'(24'h7FFFFF);
          1:       return gain_t'(24'h800000);
          default: return gain_t'(24'h000000);
        endcase
      end
      1:       return gain_t'($urandom);
      2:       return gain_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return gain_t'(int'($urandom_range(0, 1 << 13)) - (1 << 12));
    endcase
  endfunction

  task automatic send_random_sample();
    int m;
    int w;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        m = int'($urandom_range(0, 65535)) - 32768;
        w = int'($urandom_range(0, 65535)) - 32768;
      end
      3: begin
        m = $urandom_range(0, 1) ? 32767 : -32768;
        w = $urandom_range(0, 1) ? 32767 : -32768;
      end
      default: begin
        // near the target speed, so the window holds small errors
        m = int'($urandom_range(0, 65535)) - 32768;
        w = m + int'($urandom_range(0, 1024)) - 512;
        if (w > 32767)  w = 32767;
        if (w < -32768) w = -32768;
      end
    endcase
    send_sample(speed_t'(m), speed_t'(w));
  endtask

  // Only the proportional term may act until two errors are stored.
  task automatic test_sparse_window();
    wait_idle();
    write_gain(REG_KP, gain_t'(24'h010000));
    write_gain(REG_KD_EFF, gain_t'(24'h7FFFFF));
    write_gain(REG_KI_EFF, gain_t'(24'h7FFFFF));
    send_sample(0, 128);
    send_sample(0, 128);
    send_sample(64, 0);
  endtask

  // kp = 1.0: error 256 is exactly full drive, error 0 exactly zero drive.
  task automatic test_saturation();
    wait_idle();
    write_gain(REG_KD_EFF, gain_t'(24'h000000));
    write_gain(REG_KI_EFF, gain_t'(24'h000000));
    send_sample(0, 0);
    send_sample(0, 256);
    send_sample(0, 257);
    send_sample(1, 0);
    send_sample(-32768, 32767);
    send_sample(32767, -32768);
    send_sample(-32768, -32768);
    send_sample(32767, 32767);
  endtask

  task automatic test_rounding();
    wait_idle();
    write_gain(REG_KP, gain_t'(24'h000001));
    send_sample(0, 2047);
    send_sample(0, 2048);
    send_sample(0, 6143);
    send_sample(0, 6144);
    // most negative gain times -2 lands exactly on 1.0
    wait_idle();
    write_gain(REG_KP, gain_t'(24'h800000));
    send_sample(2, 0);
    // just under 1.0 rounds up to full drive without a clamp
    wait_idle();
    write_gain(REG_KP, gain_t'(24'h7FFFFF));
    send_sample(0, 2);
    // a write to the unmapped index must leave the gains alone
    wait_idle();
    write_gain(REG_UNUSED, gain_t'(24'h000000));
    send_sample(0, 2);
  endtask

  task automatic test_random_phases();
    int p;
    int i;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      allow_idle = (p != RANDOM_PHASES - 1);
      if (p == 0) begin
        write_gain(REG_KP, gain_t'(24'h7FFFFF));
        write_gain(REG_KD_EFF, gain_t'(24'h7FFFFF));
        write_gain(REG_KI_EFF, gain_t'(24'h7FFFFF));
      end else if (p == 1) begin
        write_gain(REG_KP, gain_t'(24'h800000));
        write_gain(REG_KD_EFF, gain_t'(24'h800000));
        write_gain(REG_KI_EFF, gain_t'(24'h800000));
      end else begin
        write_gain(REG_KP, rand_gain($urandom_range(0, 3)));
        write_gain(REG_KD_EFF, rand_gain($urandom_range(0, 3)));
        write_gain(REG_KI_EFF, rand_gain($urandom_range(0, 3)));
      end
      if (p == 3)
        write_gain(REG_UNUSED, rand_gain(1));
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 2 && i == 40)
          hold_off_req = 1'b1;
        send_random_sample();
      end
    end
  endtask

  // Drive sink: random stalls, plus one long hold-off on request.
  initial begin : drive_sink
    drive_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        drive_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (allow_idle && $urandom_range(0, 4) == 0) begin
        drive_ch.ready = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        drive_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      results_seen++;
      if (drive_ch.was_clamped === 1'b1)
        clamped_seen++;
      if (expected_drive.size() == 0) begin
        report_mismatch($sformatf("drive transaction with nothing pending: level %0d",
                                  drive_ch.drive_level));
      end else begin
        want = expected_drive.pop_front();
        if (drive_ch.drive_level !== want.level)
          report_mismatch($sformatf("result %0d drive_level got %0d want %0d",
                                    results_seen, drive_ch.drive_level, want.level));
        if (drive_ch.was_clamped !== want.clamped)
          report_mismatch($sformatf("result %0d was_clamped got %0b want %0b",
                                    results_seen, drive_ch.was_clamped, want.clamped));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("windowed_pid_speed_controller_top: mismatch");
      $finish;
    end
  end

  initial begin
    int waited;
    rst                      = 1'b1;
    sample_ch.valid          = 1'b0;
    sample_ch.measured_speed = '0;
    sample_ch.wanted_speed   = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.index             = REG_KP;
    cfg_ch.data              = '0;
    foreach (err_window[k]) err_window[k] = '0;
    err_sum   = 0;
    err_count = 0;
    next_slot = 0;
    gain_kp   = 0;
    gain_kd   = 0;
    gain_ki   = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_sparse_window();
    test_saturation();
    test_rounding();
    test_random_phases();

    @(negedge clk);
    sample_ch.valid = 1'b0;
    waited = 0;
    while (expected_drive.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (expected_drive.size() != 0)
      report_mismatch($sformatf("%0d drive results never arrived", expected_drive.size()));

    $display("Sent %0d speed samples and checked %0d drive results (%0d clamped).",
             samples_sent, results_seen, clamped_seen);
    $display("Applied %0d gain writes incl. extremes, an unmapped index and a long stall.",
             gain_writes);
    if (mismatches == 0) begin
      $display("windowed_pid_speed_controller_top: match");
    end else begin
      $display("windowed_pid_speed_controller_top: mismatch");
    end
    $finish;
  end

endmodule
